FILE: src/wcm_pkg.sv
package wcm_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_START  = 3'd1,
        CMD_PERIOD = 3'd2,
        CMD_VOLUME = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_GEN    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_ACC,
        ST_OUT
    } state_t;

    localparam logic [31:0] FACTOR_RESET = 32'd658868;
    localparam logic [31:0] STEP_RESET   = 32'd1539;
    localparam logic [6:0]  MAX_VOLUME   = 7'd64;
    localparam logic [2:0]  ACTIVE_RESET = 3'd4;
    localparam logic [15:0] LOOP_MIN     = 16'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  channel;
        logic [15:0] wave_address;
        logic [7:0]  wave_byte;
        logic [15:0] sample_length;
        logic [15:0] loop_begin;
        logic [15:0] loop_length;
        logic [15:0] start_offset;
        logic [11:0] period;
        logic [6:0]  volume;
    } word_t;

endpackage

FILE: src/wcm_front.sv
module wcm_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  wcm_pkg::word_t in_word,
    output logic          q_valid,
    input  logic          q_take,
    output wcm_pkg::word_t q_word
);

    wcm_pkg::word_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wr_reg;
    logic       rd_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = cnt_reg[1];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    assign q_valid = cnt_reg != 2'd0;
    assign q_word  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    count_ok: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg != 2'd0)
        else $error("queue emptied while full");
    take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_take && !do_push) |=> cnt_reg == $past(cnt_reg))
        else $error("queue count drifted");

endmodule

FILE: src/wcm_back.sv
module wcm_back #(
    parameter int CHANNELS   = 4,
    parameter int WAVE_DEPTH = 65536,
    parameter int FRAC_BITS  = 12
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_take,
    input  wcm_pkg::word_t q_word,
    input  logic [31:0]    factor,
    input  logic [2:0]     active,
    output logic           res_valid,
    input  logic           res_take,
    output logic [7:0]     res_data
);

    localparam int AW  = $clog2(WAVE_DEPTH);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW  = 16 + FRAC_BITS;
    localparam int NW  = $clog2(CHANNELS + 1);

    logic signed [7:0] wave_mem [WAVE_DEPTH];
    logic signed [7:0] rd_data_reg;

    logic [15:0]  base_reg  [CHANNELS];
    logic [PW-1:0] pos_reg  [CHANNELS];
    logic [16:0]  end_reg   [CHANNELS];
    logic [15:0]  lstart_reg[CHANNELS];
    logic [CHANNELS-1:0] loops_reg;
    logic [CHANNELS-1:0] play_reg;
    logic [31:0]  step_reg  [CHANNELS];
    logic [6:0]   vol_reg   [CHANNELS];

    wcm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] ch_reg;
    logic [NW-1:0] n_reg;
    logic [5:0]    dcnt_reg;
    logic [31:0]   quo_reg;
    logic [11:0]   rem_reg;
    logic signed [18:0] acc_reg;
    logic          out_v_reg;
    logic [7:0]    out_reg;
    logic          hit_reg;

    logic [2:0]  cmd;
    logic        ch_ok;
    logic [CW-1:0] chx;
    logic [NW-1:0] n_eff;
    logic        ch_hit;
    logic [PW-1:0] pos_adv;
    logic [12:0] rem_sh;
    logic [18:0] lvl_sum;
    logic signed [11:0] lvl;

    assign cmd   = q_word.command;
    assign chx   = CW'(q_word.channel);
    assign ch_ok = {30'd0, q_word.channel} < CHANNELS;
    assign n_eff = ({29'd0, active} > CHANNELS) ? NW'(CHANNELS) : NW'(active);
    assign ch_hit = play_reg[ch_reg] && ({1'b0, pos_reg[ch_reg][PW-1:FRAC_BITS]} < end_reg[ch_reg]);
    assign pos_adv = pos_reg[ch_reg] + PW'(step_reg[ch_reg]);
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign lvl_sum = 19'(acc_reg) + 19'd131072;
    assign lvl     = 12'(lvl_sum[18:8]) - 12'sd384;
    assign res_valid = out_v_reg;
    assign res_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wcm_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (cmd == wcm_pkg::CMD_PERIOD && ch_ok && q_word.period != 12'd0)
                    begin
                        state_next = wcm_pkg::ST_DIV;
                    end
                    else if (cmd == wcm_pkg::CMD_GEN && !out_v_reg)
                    begin
                        state_next = (n_eff == '0) ? wcm_pkg::ST_OUT : wcm_pkg::ST_RD;
                    end
                end
            end
            wcm_pkg::ST_DIV:
                if (dcnt_reg == 6'd32) state_next = wcm_pkg::ST_IDLE;
            wcm_pkg::ST_RD:
                state_next = wcm_pkg::ST_ACC;
            wcm_pkg::ST_ACC:
                state_next = ({1'b0, ch_reg} == NW'(n_reg - 1'b1)) ? wcm_pkg::ST_OUT
                                                                : wcm_pkg::ST_RD;
            wcm_pkg::ST_OUT:
                state_next = wcm_pkg::ST_IDLE;
            default:
                state_next = wcm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take = 1'b0;
        unique case (state_reg)
            wcm_pkg::ST_IDLE:
                q_take = q_valid && cmd != wcm_pkg::CMD_GEN
                         && !(cmd == wcm_pkg::CMD_PERIOD && ch_ok && q_word.period != 12'd0);
            wcm_pkg::ST_DIV:
                q_take = dcnt_reg == 6'd32;
            wcm_pkg::ST_OUT:
                q_take = 1'b1;
            default:
                q_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == wcm_pkg::ST_IDLE && q_valid && cmd == wcm_pkg::CMD_WRITE)
        begin
            wave_mem[AW'(q_word.wave_address)] <= q_word.wave_byte;
        end
        rd_data_reg <= wave_mem[AW'({16'd0, base_reg[ch_reg]} +
                                    {16'd0, pos_reg[ch_reg][PW-1:FRAC_BITS]})];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcm_pkg::ST_IDLE;
            for (int i = 0; i < CHANNELS; i++)
            begin
                base_reg[i]   <= '0;
                pos_reg[i]    <= '0;
                end_reg[i]    <= '0;
                lstart_reg[i] <= '0;
                step_reg[i]   <= wcm_pkg::STEP_RESET;
                vol_reg[i]    <= wcm_pkg::MAX_VOLUME;
            end
            loops_reg <= '0;
            play_reg  <= '0;
            ch_reg    <= '0;
            n_reg     <= '0;
            dcnt_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            acc_reg   <= '0;
            hit_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_take && out_v_reg)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                wcm_pkg::ST_IDLE:
                begin
                    ch_reg   <= (q_valid && cmd == wcm_pkg::CMD_GEN) ? '0 : chx;
                    dcnt_reg <= '0;
                    quo_reg  <= factor;
                    rem_reg  <= '0;
                    acc_reg  <= '0;
                    n_reg    <= n_eff;
                    if (q_valid && ch_ok)
                    begin
                        case (cmd)
                            wcm_pkg::CMD_START:
                            begin
                                base_reg[chx]   <= q_word.wave_address;
                                lstart_reg[chx] <= q_word.loop_begin;
                                if (q_word.loop_length > wcm_pkg::LOOP_MIN)
                                begin
                                    loops_reg[chx] <= 1'b1;
                                    end_reg[chx]   <= {1'b0, q_word.loop_begin}
                                                      + {1'b0, q_word.loop_length};
                                end
                                else
                                begin
                                    loops_reg[chx] <= 1'b0;
                                    end_reg[chx]   <= {1'b0, q_word.sample_length};
                                end
                                pos_reg[chx]  <= {q_word.start_offset, FRAC_BITS'(0)};
                                play_reg[chx] <= 1'b1;
                            end
                            wcm_pkg::CMD_VOLUME:
                                vol_reg[chx] <= (q_word.volume > wcm_pkg::MAX_VOLUME) ?
                                                wcm_pkg::MAX_VOLUME : q_word.volume;
                            wcm_pkg::CMD_STOP:
                                play_reg[chx] <= 1'b0;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                wcm_pkg::ST_DIV:
                begin
                    if (dcnt_reg == 6'd32)
                    begin
                        step_reg[ch_reg] <= quo_reg;
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg + 6'd1;
                        if (rem_sh >= {1'b0, q_word.period})
                        begin
                            rem_reg <= 12'(rem_sh - {1'b0, q_word.period});
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[11:0];
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                    end
                end
                wcm_pkg::ST_RD:
                begin
                    hit_reg <= ch_hit;
                    if (ch_hit)
                    begin
                        if ({1'b0, pos_adv[PW-1:FRAC_BITS]} >= end_reg[ch_reg])
                        begin
                            if (loops_reg[ch_reg])
                                pos_reg[ch_reg] <= {lstart_reg[ch_reg], FRAC_BITS'(0)};
                            else
                            begin
                                pos_reg[ch_reg]  <= pos_adv;
                                play_reg[ch_reg] <= 1'b0;
                            end
                        end
                        else
                            pos_reg[ch_reg] <= pos_adv;
                    end
                end
                wcm_pkg::ST_ACC:
                begin
                    if (hit_reg)
                    begin
                        acc_reg <= acc_reg + 19'(rd_data_reg)
                                   * 19'($signed({1'b0, vol_reg[ch_reg]}));
                    end
                    ch_reg <= ch_reg + 1'b1;
                end
                wcm_pkg::ST_OUT:
                begin
                    out_v_reg <= 1'b1;
                    out_reg   <= (lvl > 12'sd255) ? 8'd255 : (lvl < 12'sd0) ? 8'd0 : lvl[7:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    out_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wcm_pkg::ST_OUT |-> !out_v_reg)
        else $error("result overwritten");
    div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wcm_pkg::ST_DIV |-> dcnt_reg <= 6'd32)
        else $error("divider overran");
    ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wcm_pkg::ST_RD |-> {1'b0, ch_reg} < n_reg)
        else $error("channel walk out of range");

endmodule

FILE: src/wavetable_channel_mixer.sv
// channel | handshake   | words
// in      | push/full   | command, channel, wave_address, wave_byte, sample_length,
//         |             | loop_begin, loop_length, start_offset, period, volume
// out     | empty/pop   | audio_sample
// cfg     | cfg_we      | cfg_index, cfg_data (advance_factor, active_channels)
// Set period runs a serial divider (one quotient bit a cycle).
// Generate reads and accumulates each active channel in turn (one wave memory read port).
// rst_n resets all control and channel state; wave memory is unset.
// A two-word queue lets input be taken while the back end works or waits on pop.
module wavetable_channel_mixer #(
    parameter int CHANNELS   = 4,
    parameter int WAVE_DEPTH = 65536,
    parameter int FRAC_BITS  = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [1:0]  channel,
    input  logic [15:0] wave_address,
    input  logic signed [7:0] wave_byte,
    input  logic [15:0] sample_length,
    input  logic [15:0] loop_begin,
    input  logic [15:0] loop_length,
    input  logic [15:0] start_offset,
    input  logic [11:0] period,
    input  logic [6:0]  volume,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  audio_sample,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    wcm_pkg::word_t in_word;
    wcm_pkg::word_t q_word;
    logic        q_valid;
    logic        q_take;
    logic        res_valid;
    logic [31:0] factor_reg;
    logic [2:0]  active_reg;

    assign in_word = '{command, channel, wave_address, wave_byte, sample_length,
                       loop_begin, loop_length, start_offset, period, volume};
    assign empty = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= wcm_pkg::FACTOR_RESET;
            active_reg <= wcm_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            if (!cfg_index)
                factor_reg <= cfg_data;
            else
                active_reg <= cfg_data[2:0];
        end
    end

    wcm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_word (in_word),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_word  (q_word)
    );

    wcm_back #(
        .CHANNELS   (CHANNELS),
        .WAVE_DEPTH (WAVE_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_word    (q_word),
        .factor    (factor_reg),
        .active    (active_reg),
        .res_valid (res_valid),
        .res_take  (pop),
        .res_data  (audio_sample)
    );

endmodule

FILE: sim/wavetable_channel_mixer_test.sv
module wavetable_channel_mixer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 60;
    localparam int HOLD_OFF   = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  command = '0;
    logic [1:0]  channel = '0;
    logic [15:0] wave_address = '0;
    logic signed [7:0] wave_byte = '0;
    logic [15:0] sample_length = '0;
    logic [15:0] loop_begin = '0;
    logic [15:0] loop_length = '0;
    logic [15:0] start_offset = '0;
    logic [11:0] period = '0;
    logic [6:0]  volume = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  audio_sample;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    wavetable_channel_mixer u_top (.*);

    // shadow of the mixer state
    bit   [7:0]  wave_mem [65536];
    bit          wave_set [65536];
    bit   [15:0] ch_base [4];
    bit   [27:0] ch_pos [4];
    bit   [16:0] ch_end [4];
    bit   [15:0] ch_lstart [4];
    bit          ch_loops [4];
    bit   [31:0] ch_step [4];
    bit   [6:0]  ch_vol [4];
    bit          ch_playing [4];
    bit   [31:0] factor;
    bit   [2:0]  active;

    wcm_pkg::word_t word_q [$];
    bit [7:0] sample_q [$];
    int       issued = 0;
    int       received = 0;
    int       accepted = 0;
    int       errors = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic bit [7:0] mix_sample();
        int   n;
        int   acc;
        int   lvl;
        bit [15:0] ipos;
        bit [31:0] sum;
        n = (active > 3'd4) ? 4 : int'(active);
        acc = 0;
        for (int c = 0; c < n; c++)
        begin
            ipos = ch_pos[c][27:12];
            if (!ch_playing[c] || {1'b0, ipos} >= ch_end[c])
                continue;
            acc += int'($signed(wave_mem[16'(ch_base[c] + ipos)])) * int'(ch_vol[c]);
            sum = 32'(ch_pos[c]) + ch_step[c];
            ch_pos[c] = sum[27:0];
            if ({1'b0, ch_pos[c][27:12]} >= ch_end[c])
            begin
                if (ch_loops[c])
                    ch_pos[c] = {ch_lstart[c], 12'd0};
                else
                    ch_playing[c] = 1'b0;
            end
        end
        lvl = (acc >>> 8) + 128;
        if (lvl > 255)
            lvl = 255;
        if (lvl < 0)
            lvl = 0;
        return lvl[7:0];
    endfunction

    task automatic apply_word(wcm_pkg::word_t w);
        int c;
        c = int'(w.channel);
        case (w.command)
            wcm_pkg::CMD_WRITE:
            begin
                wave_mem[w.wave_address] = w.wave_byte;
                wave_set[w.wave_address] = 1'b1;
            end
            wcm_pkg::CMD_GEN:
                sample_q.push_back(mix_sample());
            wcm_pkg::CMD_START:
            begin
                ch_base[c] = w.wave_address;
                ch_lstart[c] = w.loop_begin;
                ch_loops[c] = w.loop_length > wcm_pkg::LOOP_MIN;
                ch_end[c] = ch_loops[c] ? 17'(w.loop_begin) + 17'(w.loop_length)
                                        : 17'(w.sample_length);
                ch_pos[c] = {w.start_offset, 12'd0};
                ch_playing[c] = 1'b1;
            end
            wcm_pkg::CMD_PERIOD:
                if (w.period != 12'd0)
                    ch_step[c] = factor / w.period;
            wcm_pkg::CMD_VOLUME:
                ch_vol[c] = (w.volume > wcm_pkg::MAX_VOLUME) ? wcm_pkg::MAX_VOLUME : w.volume;
            wcm_pkg::CMD_STOP:
                ch_playing[c] = 1'b0;
            default: ;
        endcase
        word_q.push_back(w);
    endtask

    function automatic wcm_pkg::word_t rand_word();
        wcm_pkg::word_t w;
        w.command = 3'($urandom_range(0, 7));
        w.channel = 2'($urandom);
        w.wave_address = 16'($urandom);
        w.wave_byte = 8'($urandom);
        w.sample_length = 16'($urandom);
        w.loop_begin = 16'($urandom);
        w.loop_length = 16'($urandom);
        w.start_offset = 16'($urandom);
        w.period = 12'($urandom);
        w.volume = 7'($urandom);
        return w;
    endfunction

    // before a generate, fill any wave byte that a playing channel is about to read
    task automatic send(wcm_pkg::word_t w);
        wcm_pkg::word_t wr;
        int    n;
        bit [15:0] ipos;
        bit [15:0] a;
        if (w.command == wcm_pkg::CMD_GEN)
        begin
            n = (active > 3'd4) ? 4 : int'(active);
            for (int c = 0; c < n; c++)
            begin
                ipos = ch_pos[c][27:12];
                a = ch_base[c] + ipos;
                if (ch_playing[c] && {1'b0, ipos} < ch_end[c] && !wave_set[a])
                begin
                    wr = rand_word();
                    wr.command = wcm_pkg::CMD_WRITE;
                    wr.wave_address = a;
                    apply_word(wr);
                end
            end
        end
        apply_word(w);
    endtask

    task automatic settle();
        while (word_q.size() != 0 || received != issued)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(bit idx, bit [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx)
            active = val[2:0];
        else
            factor = val;
    endtask

    task automatic send_one(wcm_pkg::cmd_t cmd, int ch, int addr, int data);
        wcm_pkg::word_t w;
        w = rand_word();
        w.command = cmd;
        w.channel = 2'(ch);
        w.wave_address = 16'(addr);
        w.wave_byte = 8'(data);
        w.period = 12'(data);
        w.volume = 7'(data);
        send(w);
    endtask

    task automatic run_random(int count);
        wcm_pkg::word_t w;
        int    k;
        for (int i = 0; i < count; i++)
        begin
            w = rand_word();
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                // noise: whatever the fields give
            end
            else if (k < 60)
                w.command = wcm_pkg::CMD_GEN;
            else if (k < 72)
            begin
                w.command = wcm_pkg::CMD_START;
                if ($urandom_range(0, 9) != 0)
                begin
                    w.sample_length = 16'($urandom_range(0, 48));
                    w.loop_begin = 16'($urandom_range(0, 24));
                    w.loop_length = 16'($urandom_range(0, 24));
                    w.start_offset = 16'($urandom_range(0, 16));
                end
                else if ($urandom_range(0, 1) != 0)
                begin
                    w.start_offset = 16'(32'hFFFF - $urandom_range(0, 3));
                    w.sample_length = 16'hFFFF;
                end
            end
            else if (k < 82)
            begin
                w.command = wcm_pkg::CMD_PERIOD;
                if ($urandom_range(0, 3) == 0)
                    w.period = 12'($urandom_range(0, 3));
            end
            else if (k < 90)
                w.command = wcm_pkg::CMD_VOLUME;
            else if (k < 94)
                w.command = wcm_pkg::CMD_STOP;
            else
                w.command = wcm_pkg::CMD_WRITE;
            send(w);
        end
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;
    bit pausing = 1'b0;
    bit paused_once = 1'b0;

    always @(posedge clk)
    begin
        wcm_pkg::word_t w;
        bit    offer;
        if (push && !full)
        begin
            w = word_q.pop_front();
            if (w.command == wcm_pkg::CMD_GEN)
                issued++;
            accepted++;
        end
        if (!paused_once && accepted == 450)
        begin
            paused_once = 1'b1;
            pausing = 1'b1;
        end
        if (pausing && received == issued)
            pausing = 1'b0;
        offer = 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0)
            gap_left--;
        else
        begin
            burst_left--;
            offer = !pausing && rst_n && word_q.size() != 0;
        end
        push <= offer;
        if (word_q.size() != 0)
        begin
            command <= word_q[0].command;
            channel <= word_q[0].channel;
            wave_address <= word_q[0].wave_address;
            wave_byte <= word_q[0].wave_byte;
            sample_length <= word_q[0].sample_length;
            loop_begin <= word_q[0].loop_begin;
            loop_length <= word_q[0].loop_length;
            start_offset <= word_q[0].start_offset;
            period <= word_q[0].period;
            volume <= word_q[0].volume;
        end
    end

    // monitor
    int  cyc = 0;
    int  stall_left = 0;
    bit  stalled_once = 1'b0;

    always @(posedge clk)
    begin
        bit [7:0] want;
        bit       take;
        if (pop && !empty)
        begin
            if (sample_q.size() == 0)
                report("unexpected audio_sample", audio_sample, -1);
            else
            begin
                want = sample_q.pop_front();
                if (audio_sample !== want)
                    report("audio_sample", audio_sample, want);
            end
            received++;
        end
        if (!stalled_once && received == 120)
        begin
            stalled_once = 1'b1;
            stall_left = HOLD_OFF;
        end
        cyc++;
        case ((cyc >> 6) % 4)
            0: take = 1'b1;
            1: take = (cyc % 4) != 0;
            2: take = $urandom_range(0, 1) != 0;
            default: take = (cyc % 5) == 0;
        endcase
        if (stall_left > 0)
        begin
            stall_left--;
            take = 1'b0;
        end
        pop <= take && rst_n;
    end

    // watchdog
    int idle = 0;

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle = 0;
        else
            idle++;
        if (idle >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        factor = wcm_pkg::FACTOR_RESET;
        active = wcm_pkg::ACTIVE_RESET;
        for (int c = 0; c < 4; c++)
        begin
            ch_step[c] = wcm_pkg::STEP_RESET;
            ch_vol[c] = wcm_pkg::MAX_VOLUME;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, loop and no-loop, period zero, unknown codes
        send_one(wcm_pkg::CMD_WRITE, 0, 16'h0000, -128);
        send_one(wcm_pkg::CMD_WRITE, 0, 16'h0001, 127);
        send_one(wcm_pkg::CMD_WRITE, 0, 16'hFFFF, 127);
        send_one(wcm_pkg::CMD_GEN, 0, 0, 0);
        begin
            wcm_pkg::word_t w;
            w = rand_word();
            w.command = wcm_pkg::CMD_START; w.channel = 2'd0; w.wave_address = 16'hFFFF;
            w.loop_begin = 16'd0; w.loop_length = 16'd3; w.start_offset = 16'd0;
            send(w);
            w = rand_word();
            w.command = wcm_pkg::CMD_START; w.channel = 2'd3; w.wave_address = 16'd0;
            w.loop_length = 16'd2; w.sample_length = 16'd2; w.start_offset = 16'd0;
            send(w);
        end
        send_one(wcm_pkg::CMD_VOLUME, 3, 0, 127);
        send_one(wcm_pkg::CMD_VOLUME, 0, 0, 0);
        send_one(wcm_pkg::CMD_GEN, 0, 0, 0);
        send_one(wcm_pkg::CMD_VOLUME, 0, 0, 64);
        send_one(wcm_pkg::CMD_PERIOD, 0, 0, 0);
        send_one(wcm_pkg::CMD_PERIOD, 1, 0, 4095);
        send_one(wcm_pkg::CMD_PERIOD, 3, 0, 1);
        send_one(wcm_pkg::CMD_GEN, 0, 0, 0);
        send_one(wcm_pkg::CMD_GEN, 0, 0, 0);
        send_one(wcm_pkg::CMD_STOP, 0, 0, 0);
        send_one(wcm_pkg::cmd_t'(3'd6), 2, 0, 0);
        send_one(wcm_pkg::cmd_t'(3'd7), 1, 0, 0);
        send_one(wcm_pkg::CMD_GEN, 0, 0, 0);
        send_one(wcm_pkg::CMD_PERIOD, 2, 0, 428);
        send_one(wcm_pkg::CMD_GEN, 0, 0, 0);

        run_random(130);
        settle();
        write_cfg(1'b0, 32'hFFFF_FFFF);
        write_cfg(1'b1, 32'd1);
        run_random(130);
        settle();
        write_cfg(1'b0, 32'd0);
        write_cfg(1'b1, 32'd0);
        run_random(110);
        settle();
        write_cfg(1'b0, $urandom);
        write_cfg(1'b1, 32'd7);
        run_random(130);
        settle();
        write_cfg(1'b0, 32'd2635472);
        write_cfg(1'b1, 32'd5);
        run_random(130);
        settle();
        write_cfg(1'b0, wcm_pkg::FACTOR_RESET);
        write_cfg(1'b1, 32'd3);
        run_random(130);
        settle();

        if (errors == 0 && sample_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
